>>> rtl/core/dtl_pkg.sv
// Shared types, constants and helper functions for the DDS tuning word loader.
package dtl_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned REF_W      = 27;
    localparam int unsigned PHASE_W    = 5;
    localparam int unsigned BYTE_W     = 8;

    // Dividend is hz << 32; the top bits of hz seed the remainder directly,
    // since hz >> PRE_BITS is always below the smallest reference.
    localparam int unsigned PRE_BITS        = 8;
    localparam int unsigned DIV_STEPS       = PRE_BITS + WORD_W;
    localparam int unsigned STEPS_PER_STAGE = 4;
    localparam int unsigned DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;

    localparam logic [REF_W-1:0] REF_MIN_HZ   = REF_W'(120000000);
    localparam logic [REF_W-1:0] REF_MAX_HZ   = REF_W'(130000000);
    localparam logic [REF_W-1:0] REF_RESET_HZ = REF_W'(125000000);

    // Result sequence positions
    localparam int unsigned      SEQ_W        = 4;
    localparam logic [SEQ_W-1:0] SEQ_PHASE_R  = SEQ_W'(0);
    localparam logic [SEQ_W-1:0] SEQ_PHASE_L  = SEQ_W'(5);
    localparam logic [SEQ_W-1:0] SEQ_UPDATE   = SEQ_W'(10);

    localparam logic KIND_RAW = 1'b0;
    localparam logic KIND_HZ  = 1'b1;

    localparam logic ACTION_STROBE = 1'b0;
    localparam logic ACTION_UPDATE = 1'b1;

    localparam logic CHIP_RIGHT = 1'b0;
    localparam logic CHIP_LEFT  = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [WORD_W-1:0]  value_right;
        logic [WORD_W-1:0]  value_left;
        logic [WORD_W-1:0]  offset_right;
        logic [WORD_W-1:0]  offset_left;
        logic [PHASE_W-1:0] phase_right;
        logic [PHASE_W-1:0] phase_left;
    } dtl_item_t;

    typedef struct packed {
        logic [REF_W-1:0]  rem;
        logic [WORD_W-1:0] quo;
    } dtl_div_t;

    // Add a signed offset to a word, saturating at zero and all ones
    function automatic logic [WORD_W-1:0] add_offset(
        input logic [WORD_W-1:0] base,
        input logic [WORD_W-1:0] off
    );
        logic [WORD_W:0]   sum;
        logic [WORD_W-1:0] mag;
        logic [WORD_W-1:0] res;
        sum = {1'b0, base} + {1'b0, off};
        mag = WORD_W'(0) - off;
        if (!off[WORD_W-1]) begin
            res = sum[WORD_W] ? {WORD_W{1'b1}} : sum[WORD_W-1:0];
        end else begin
            res = (base < mag) ? '0 : (base - mag);
        end
        return res;
    endfunction

    // Clamp a reference write into the legal range
    function automatic logic [REF_W-1:0] clamp_ref(input logic [REF_W-1:0] v);
        logic [REF_W-1:0] res;
        res = v;
        if (v < REF_MIN_HZ) res = REF_MIN_HZ;
        if (v > REF_MAX_HZ) res = REF_MAX_HZ;
        return res;
    endfunction

endpackage

>>> rtl/core/dtl_div_pipe.sv
// Pipelined restoring divider: (hz << 32) / reference for both chips.
module dtl_div_pipe (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_valid,
    input  dtl_pkg::dtl_item_t            in_item,
    input  logic [dtl_pkg::REF_W-1:0]     ref_hz,
    output logic                          out_valid,
    output dtl_pkg::dtl_item_t            out_item,
    output logic [dtl_pkg::WORD_W-1:0]    out_quo_right,
    output logic [dtl_pkg::WORD_W-1:0]    out_quo_left
);

    logic               valid_reg [dtl_pkg::DIV_STAGES];
    dtl_pkg::dtl_item_t item_reg  [dtl_pkg::DIV_STAGES];
    dtl_pkg::dtl_div_t  div_reg   [dtl_pkg::DIV_STAGES][2];

    genvar g;
    generate
        for (g = 0; g < dtl_pkg::DIV_STAGES; g++) begin : g_stage
            logic               prev_valid;
            dtl_pkg::dtl_item_t prev_item;
            dtl_pkg::dtl_div_t  prev_div [2];
            dtl_pkg::dtl_div_t  div_next [2];

            // Select stage input: ports seed the remainder with the top of hz
            if (g == 0) begin : g_first
                always_comb begin
                    prev_valid      = in_valid;
                    prev_item       = in_item;
                    prev_div[0].rem = dtl_pkg::REF_W'(
                        in_item.value_right[dtl_pkg::WORD_W-1:dtl_pkg::PRE_BITS]);
                    prev_div[0].quo = '0;
                    prev_div[1].rem = dtl_pkg::REF_W'(
                        in_item.value_left[dtl_pkg::WORD_W-1:dtl_pkg::PRE_BITS]);
                    prev_div[1].quo = '0;
                end
            end else begin : g_rest
                always_comb begin
                    prev_valid  = valid_reg[g-1];
                    prev_item   = item_reg[g-1];
                    prev_div[0] = div_reg[g-1][0];
                    prev_div[1] = div_reg[g-1][1];
                end
            end

            // Run this stage's compare-subtract steps on both lanes
            always_comb begin
                logic [dtl_pkg::REF_W:0]    t;
                logic [dtl_pkg::REF_W-1:0]  r;
                logic [dtl_pkg::WORD_W-1:0] q;
                logic [dtl_pkg::WORD_W-1:0] v;
                logic                       b;
                logic                       qb;
                int                         j;
                for (int ln = 0; ln < 2; ln++) begin
                    r = prev_div[ln].rem;
                    q = prev_div[ln].quo;
                    v = (ln == 0) ? prev_item.value_right : prev_item.value_left;
                    for (int k = 0; k < dtl_pkg::STEPS_PER_STAGE; k++) begin
                        j  = g * dtl_pkg::STEPS_PER_STAGE + k;
                        b  = (j < dtl_pkg::PRE_BITS) ?
                             v[5'(dtl_pkg::PRE_BITS - 1 - j)] : 1'b0;
                        t  = {r, b};
                        qb = (t >= {1'b0, ref_hz});
                        if (qb) t = t - {1'b0, ref_hz};
                        r  = t[dtl_pkg::REF_W-1:0];
                        q  = {q[dtl_pkg::WORD_W-2:0], qb};
                    end
                    div_next[ln].rem = r;
                    div_next[ln].quo = q;
                end
            end

            // Advance valid with the data; hold everything on a stall
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[g] <= 1'b0;
                end else if (adv) begin
                    valid_reg[g] <= prev_valid;
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    item_reg[g]   <= prev_item;
                    div_reg[g][0] <= div_next[0];
                    div_reg[g][1] <= div_next[1];
                end
            end
        end
    endgenerate

    assign out_valid     = valid_reg[dtl_pkg::DIV_STAGES-1];
    assign out_item      = item_reg[dtl_pkg::DIV_STAGES-1];
    assign out_quo_right = div_reg[dtl_pkg::DIV_STAGES-1][0].quo;
    assign out_quo_left  = div_reg[dtl_pkg::DIV_STAGES-1][1].quo;

endmodule

>>> rtl/core/dtl_serializer.sv
// Word finish and bus sequencer: eleven results per request.
module dtl_serializer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    input  dtl_pkg::dtl_item_t             in_item,
    input  logic [dtl_pkg::WORD_W-1:0]     in_quo_right,
    input  logic [dtl_pkg::WORD_W-1:0]     in_quo_left,
    output logic                           in_take,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_action,
    output logic                           m_chip,
    output logic [dtl_pkg::BYTE_W-1:0]     m_bus_byte,
    output logic                           m_last
);

    logic                          busy_reg;
    logic [dtl_pkg::SEQ_W-1:0]     seq_reg;
    logic [dtl_pkg::WORD_W-1:0]    word_r_reg;
    logic [dtl_pkg::WORD_W-1:0]    word_l_reg;
    logic [dtl_pkg::PHASE_W-1:0]   phase_r_reg;
    logic [dtl_pkg::PHASE_W-1:0]   phase_l_reg;
    logic [dtl_pkg::WORD_W-1:0]    word_r_next;
    logic [dtl_pkg::WORD_W-1:0]    word_l_next;
    logic                          done;

    assign done    = busy_reg && m_ready && (seq_reg == dtl_pkg::SEQ_UPDATE);
    assign in_take = in_valid && (!busy_reg || done);

    // Finish the words: raw pass-through or quotient plus saturated offset
    always_comb begin
        if (in_item.kind == dtl_pkg::KIND_HZ) begin
            word_r_next = dtl_pkg::add_offset(in_quo_right, in_item.offset_right);
            word_l_next = dtl_pkg::add_offset(in_quo_left, in_item.offset_left);
        end else begin
            word_r_next = in_item.value_right;
            word_l_next = in_item.value_left;
        end
    end

    // Step the sequence on each accepted result; load the next request when idle or at the end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            seq_reg  <= '0;
        end else if (in_take) begin
            busy_reg <= 1'b1;
            seq_reg  <= '0;
        end else if (done) begin
            busy_reg <= 1'b0;
            seq_reg  <= '0;
        end else if (busy_reg && m_ready) begin
            seq_reg  <= seq_reg + dtl_pkg::SEQ_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            word_r_reg  <= word_r_next;
            word_l_reg  <= word_l_next;
            phase_r_reg <= in_item.phase_right;
            phase_l_reg <= in_item.phase_left;
        end
    end

    // Drive the result fields from the sequence position
    always_comb begin
        m_valid    = busy_reg;
        m_action   = dtl_pkg::ACTION_STROBE;
        m_last     = 1'b0;
        m_chip     = (seq_reg >= dtl_pkg::SEQ_PHASE_L) ? dtl_pkg::CHIP_LEFT
                                                        : dtl_pkg::CHIP_RIGHT;
        case (seq_reg)
            4'd0:    m_bus_byte = {phase_r_reg, 3'b000};
            4'd1:    m_bus_byte = word_r_reg[31:24];
            4'd2:    m_bus_byte = word_r_reg[23:16];
            4'd3:    m_bus_byte = word_r_reg[15:8];
            4'd4:    m_bus_byte = word_r_reg[7:0];
            4'd5:    m_bus_byte = {phase_l_reg, 3'b000};
            4'd6:    m_bus_byte = word_l_reg[31:24];
            4'd7:    m_bus_byte = word_l_reg[23:16];
            4'd8:    m_bus_byte = word_l_reg[15:8];
            4'd9:    m_bus_byte = word_l_reg[7:0];
            default: m_bus_byte = '0;
        endcase
        if (seq_reg == dtl_pkg::SEQ_UPDATE) begin
            m_action = dtl_pkg::ACTION_UPDATE;
            m_chip   = dtl_pkg::CHIP_RIGHT;
            m_last   = 1'b1;
        end
    end

    a_seq_range: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg <= dtl_pkg::SEQ_UPDATE)
        else $error("sequence position out of range");

    a_take_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |=> busy_reg && seq_reg == '0)
        else $error("loaded request does not start at first byte");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !m_ready |=> busy_reg && $stable(seq_reg))
        else $error("sequence moved while receiver stalled");

    a_no_take_midway: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !done |-> !in_take)
        else $error("request loaded over an unfinished one");

endmodule

>>> rtl/core/dds_tuning_word_loader_top.sv
// DDS tuning word loader top level: reference register, divider pipe, sequencer.
//
// Input channel (s_valid/s_ready): one request carries kind, two values, two
// signed offsets and two phases. With kind 1 each value is hertz and becomes
// floor((hz << 32) / ref_clk_hz) plus the offset, saturated to 32 bits.
// Result channel (m_valid/m_ready): eleven results per request: five byte
// strobes to the right chip (phase << 3, then word MSB first), five to the
// left chip, then the update pulse with m_last high.
// Divider: ten stages of four quotient bits each (40 bits in all). A request
// moves through the stages in order while the pipe advances; the sequencer
// loads it from the last stage and presents its first result right away.
// The sequencer takes a new request only when idle or as the last of its
// eleven results is accepted; requests are accepted back to back while the
// last divider stage is empty or handing its request to the sequencer.
// cfg_we/cfg_wdata write ref_clk_hz, clamped to 120..130 MHz; write only
// while the block is idle. Reset sets ref_clk_hz to 125 MHz and empties the
// pipe. When the receiver stalls, results hold; once the last divider stage
// holds a request the sequencer cannot take, s_ready drops and the whole pipe
// holds. Nothing is lost or repeated.
module dds_tuning_word_loader_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [dtl_pkg::REF_W-1:0]      cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_kind,
    input  logic [dtl_pkg::WORD_W-1:0]     s_value_right,
    input  logic [dtl_pkg::WORD_W-1:0]     s_value_left,
    input  logic signed [dtl_pkg::WORD_W-1:0] s_offset_right,
    input  logic signed [dtl_pkg::WORD_W-1:0] s_offset_left,
    input  logic [dtl_pkg::PHASE_W-1:0]    s_phase_right,
    input  logic [dtl_pkg::PHASE_W-1:0]    s_phase_left,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_action,
    output logic                           m_chip,
    output logic [dtl_pkg::BYTE_W-1:0]     m_bus_byte,
    output logic                           m_last
);

    logic [dtl_pkg::REF_W-1:0]  ref_hz_reg;
    dtl_pkg::dtl_item_t         in_item;
    dtl_pkg::dtl_item_t         pipe_item;
    logic                       pipe_valid;
    logic [dtl_pkg::WORD_W-1:0] quo_right;
    logic [dtl_pkg::WORD_W-1:0] quo_left;
    logic                       take;
    logic                       adv;

    // Hold the clamped reference frequency
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_hz_reg <= dtl_pkg::REF_RESET_HZ;
        end else if (cfg_we) begin
            ref_hz_reg <= dtl_pkg::clamp_ref(cfg_wdata);
        end
    end

    always_comb begin
        in_item.kind         = s_kind;
        in_item.value_right  = s_value_right;
        in_item.value_left   = s_value_left;
        in_item.offset_right = s_offset_right;
        in_item.offset_left  = s_offset_left;
        in_item.phase_right  = s_phase_right;
        in_item.phase_left   = s_phase_left;
    end

    // Advance the pipe while its last stage is empty or being drained
    assign adv     = !pipe_valid || take;
    assign s_ready = adv;

    dtl_div_pipe u_div (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .in_valid      (s_valid),
        .in_item       (in_item),
        .ref_hz        (ref_hz_reg),
        .out_valid     (pipe_valid),
        .out_item      (pipe_item),
        .out_quo_right (quo_right),
        .out_quo_left  (quo_left)
    );

    dtl_serializer u_ser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (pipe_valid),
        .in_item       (pipe_item),
        .in_quo_right  (quo_right),
        .in_quo_left   (quo_left),
        .in_take       (take),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_action      (m_action),
        .m_chip        (m_chip),
        .m_bus_byte    (m_bus_byte),
        .m_last        (m_last)
    );

endmodule
